[design/sgs_pkg.sv]
// ----------------------------------------------------------------------------
// sgs_pkg: shared types and constants of the servo gripper sequencer
// Field widths, opcodes, register indexes, reset values and the
// constants of the duty scaling.
// ----------------------------------------------------------------------------
package sgs_pkg;

  localparam int PWM_FREQ_HZ_DEF = 50;
  localparam int PWM_BITS_DEF    = 14;

  localparam int OP_W    = 2;
  localparam int TIME_W  = 32;
  localparam int MV_W    = 12;
  localparam int PULSE_W = 12;
  localparam int STEP_W  = 10;
  localparam int PER_W   = 16;
  localparam int STATE_W = 3;
  localparam int DUTY_W  = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - MV_W - DUTY_W - PULSE_W - STATE_W;

  // Duty scaling: floor(p * F * FULL / 1e6) = floor((x >> 6) / 15625).
  localparam int  K_W         = 25;
  localparam int  X_W         = PULSE_W + K_W;
  localparam int  PRE_SHIFT   = 6;
  localparam int  Y_W         = 30;
  localparam int  RECIP_SHIFT = 44;
  localparam int  RECIP_W     = 31;
  localparam int  MUL2_W      = Y_W + RECIP_W;
  localparam longint unsigned ODD_DIV = 15625;
  localparam longint unsigned RECIP   =
    ((64'd1 << RECIP_SHIFT) + ODD_DIV - 64'd1) / ODD_DIV;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  localparam logic [CFG_ADDR_W-1:0] REG_OPEN_PULSE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CLOSED_PULSE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP         = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CONTACT      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PULSE    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PULSE    = 3'd7;

  localparam logic [PULSE_W-1:0] OPEN_PULSE_RST   = 12'd2000;
  localparam logic [PULSE_W-1:0] CLOSED_PULSE_RST = 12'd1000;
  localparam logic [STEP_W-1:0]  STEP_RST         = 10'd10;
  localparam logic [PER_W-1:0]   PERIOD_RST       = 16'd20;
  localparam logic [TIME_W-1:0]  TIMEOUT_RST      = 32'd5000;
  localparam logic [MV_W-1:0]    CONTACT_RST      = 12'd1000;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST    = 12'd500;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST    = 12'd2500;

  typedef struct packed {
    logic [PULSE_W-1:0] min_pulse;
    logic [PULSE_W-1:0] max_pulse;
  } clamp_t;

endpackage

[design/sgs_duty.sv]
// ----------------------------------------------------------------------------
// sgs_duty: PWM duty computation
// Clamps the pulse width, scales it to a compare value and saturates.
// Two register stages, both advanced by one enable.
// ----------------------------------------------------------------------------
module sgs_duty
  import sgs_pkg::*;
#(
  parameter int PWM_FREQ_HZ = PWM_FREQ_HZ_DEF,
  parameter int PWM_BITS    = PWM_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [PULSE_W-1:0] pulse,
  input  clamp_t             clamp,
  output logic [DUTY_W-1:0]  duty
);

  localparam longint unsigned FULL  = (64'd1 << PWM_BITS) - 64'd1;
  localparam longint unsigned K_VAL = FULL * PWM_FREQ_HZ;
  localparam longint unsigned SAT_Y = (FULL + 64'd1) * ODD_DIV;

  logic [PULSE_W-1:0] cp;
  logic [X_W-1:0]     x_nxt;
  logic [X_W-1:0]     x_r;
  logic [X_W-1:0]     y;
  logic               sat_nxt;
  logic               sat_r;
  logic [MUL2_W-1:0]  prod_nxt;
  logic [MUL2_W-1:0]  prod_r;

  always_comb begin
    cp = pulse;
    if (cp > clamp.max_pulse) begin
      cp = clamp.max_pulse;
    end
    if (cp < clamp.min_pulse) begin
      cp = clamp.min_pulse;
    end
    x_nxt = X_W'(cp) * X_W'(K_VAL);
  end

  always_comb begin
    y        = x_r >> PRE_SHIFT;
    sat_nxt  = (y >= X_W'(SAT_Y));
    prod_nxt = MUL2_W'(y[Y_W-1:0]) * MUL2_W'(RECIP);
  end

  always_comb begin
    if (sat_r) begin
      duty = DUTY_W'(FULL);
    end else begin
      duty = prod_r[RECIP_SHIFT +: DUTY_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      sat_r  <= sat_nxt;
      prod_r <= prod_nxt;
    end
  end

endmodule

[design/servo_gripper_sequencer_top.sv]
// ----------------------------------------------------------------------------
// servo_gripper_sequencer_top: servo gripper motion sequencer
// Applies tick, open, close and stop requests to the gripper state and
// returns one result per request with state, pulse width and PWM duty.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel carries an opcode, a millisecond
// timestamp and a force sample. The gripper state is updated in the cycle
// the request is accepted, so one request can be accepted every cycle
// while the output is not stalled. Each request yields exactly one result
// on the out_ channel, in order. The duty value goes through a clamp, a
// multiply and a reciprocal division stage. Throughput is one request per
// cycle; the pipeline of four result registers holds while out_tvalid is
// high and out_tready is low, and in_tready then stays low. The user
// must write registers on the cfg_ port only while no request is in
// flight; the block does not enforce this. Reset returns all registers
// to their default values, empties the pipeline and sets the gripper to
// stopped with the pulse width at 2000 us. A fault stays until reset.
// ----------------------------------------------------------------------------
module servo_gripper_sequencer_top
  import sgs_pkg::*;
#(
  parameter int PWM_FREQ_HZ = PWM_FREQ_HZ_DEF,
  parameter int PWM_BITS    = PWM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // now_ms[31:0], force_sample_mv[43:32], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // grip_state[2:0], pulse_us[14:3], duty[30:15], force_mv[42:31], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // duty_write[0]
  output logic                  out_tuser
);

  typedef enum logic [STATE_W-1:0] {
    ST_STOPPED = 3'd0,
    ST_OPENING = 3'd1,
    ST_CLOSING = 3'd2,
    ST_OPEN    = 3'd3,
    ST_CLOSED  = 3'd4,
    ST_CONTACT = 3'd5,
    ST_FAULT   = 3'd6
  } mode_t;

  typedef struct packed {
    logic [STATE_W-1:0] grip_state;
    logic [PULSE_W-1:0] pulse;
    logic               wrote;
    logic [MV_W-1:0]    force_mv;
  } res_t;

  logic [PULSE_W-1:0] open_pulse_r;
  logic [PULSE_W-1:0] closed_pulse_r;
  logic [STEP_W-1:0]  step_r;
  logic [PER_W-1:0]   period_r;
  logic [TIME_W-1:0]  timeout_r;
  logic [MV_W-1:0]    contact_r;
  clamp_t             clamp_r;

  mode_t              mode_r, mode_nxt;
  logic [PULSE_W-1:0] pulse_r, pulse_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic [TIME_W-1:0]  last_r, last_nxt;
  logic [MV_W-1:0]    force_r, force_nxt;
  logic               wrote_nxt;

  op_t                op;
  logic [TIME_W-1:0]  now;
  logic [MV_W-1:0]    sample;
  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-1:0]  since_step;
  logic [PULSE_W:0]   up_sum;
  logic [PULSE_W:0]   down_diff;

  logic               advance;
  logic               accept;
  logic               s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  res_t               s1_r, s2_r, s3_r;
  res_t               out_res_r;
  logic [DUTY_W-1:0]  duty_calc;
  logic [DUTY_W-1:0]  out_duty_r;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;
  assign accept    = in_tvalid && advance;

  assign op     = op_t'(in_tuser);
  assign now    = in_tdata[TIME_W-1:0];
  assign sample = in_tdata[TIME_W +: MV_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_pulse_r      <= OPEN_PULSE_RST;
      closed_pulse_r    <= CLOSED_PULSE_RST;
      step_r            <= STEP_RST;
      period_r          <= PERIOD_RST;
      timeout_r         <= TIMEOUT_RST;
      contact_r         <= CONTACT_RST;
      clamp_r.min_pulse <= MIN_PULSE_RST;
      clamp_r.max_pulse <= MAX_PULSE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OPEN_PULSE:   open_pulse_r      <= cfg_wdata[PULSE_W-1:0];
        REG_CLOSED_PULSE: closed_pulse_r    <= cfg_wdata[PULSE_W-1:0];
        REG_STEP:         step_r            <= cfg_wdata[STEP_W-1:0];
        REG_PERIOD:       period_r          <= cfg_wdata[PER_W-1:0];
        REG_TIMEOUT:      timeout_r         <= cfg_wdata[TIME_W-1:0];
        REG_CONTACT:      contact_r         <= cfg_wdata[MV_W-1:0];
        REG_MIN_PULSE:    clamp_r.min_pulse <= cfg_wdata[PULSE_W-1:0];
        REG_MAX_PULSE:    clamp_r.max_pulse <= cfg_wdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    pulse_nxt  = pulse_r;
    start_nxt  = start_r;
    last_nxt   = last_r;
    force_nxt  = force_r;
    wrote_nxt  = 1'b0;
    elapsed    = now - start_r;
    since_step = now - last_r;
    up_sum     = {1'b0, pulse_r} + (PULSE_W+1)'(step_r);
    down_diff  = {1'b0, pulse_r} - (PULSE_W+1)'(step_r);
    unique case (op) inside
      OP_OPEN, OP_CLOSE: begin
        if (mode_r != ST_FAULT) begin
          mode_nxt  = (op == OP_OPEN) ? ST_OPENING : ST_CLOSING;
          start_nxt = now;
          last_nxt  = '0;
        end
      end
      OP_STOP: begin
        if (mode_r != ST_FAULT) begin
          mode_nxt = ST_STOPPED;
        end
      end
      default: begin
        force_nxt = sample;
        if (mode_r == ST_OPENING || mode_r == ST_CLOSING) begin
          if (elapsed > timeout_r) begin
            mode_nxt = ST_FAULT;
          end else if (since_step >= TIME_W'(period_r)) begin
            last_nxt = now;
            if (mode_r == ST_CLOSING && sample >= contact_r) begin
              mode_nxt = ST_CONTACT;
            end else if (mode_r == ST_OPENING) begin
              wrote_nxt = 1'b1;
              if (up_sum < {1'b0, open_pulse_r}) begin
                pulse_nxt = up_sum[PULSE_W-1:0];
              end else begin
                pulse_nxt = open_pulse_r;
                mode_nxt  = ST_OPEN;
              end
            end else begin
              wrote_nxt = 1'b1;
              if ($signed(down_diff) > $signed({1'b0, closed_pulse_r})) begin
                pulse_nxt = down_diff[PULSE_W-1:0];
              end else begin
                pulse_nxt = closed_pulse_r;
                mode_nxt  = ST_CLOSED;
              end
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ST_STOPPED;
      pulse_r <= OPEN_PULSE_RST;
      start_r <= '0;
      last_r  <= '0;
      force_r <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pulse_r <= pulse_nxt;
      start_r <= start_nxt;
      last_r  <= last_nxt;
      force_r <= force_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r       <= '{grip_state: mode_nxt, pulse: pulse_nxt, wrote: wrote_nxt,
                      force_mv: force_nxt};
      s2_r       <= s1_r;
      s3_r       <= s2_r;
      out_res_r  <= s3_r;
      out_duty_r <= s3_r.wrote ? duty_calc : '0;
    end
  end

  sgs_duty #(
    .PWM_FREQ_HZ (PWM_FREQ_HZ),
    .PWM_BITS    (PWM_BITS)
  ) u_duty (
    .clk   (clk),
    .en    (advance),
    .pulse (s1_r.pulse),
    .clamp (clamp_r),
    .duty  (duty_calc)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.wrote;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res_r.force_mv, out_duty_r,
                       out_res_r.pulse, out_res_r.grip_state};

endmodule
